/* rtl/mpsm_pkg.sv */
// Shared constants for the multi-pattern string matcher: field widths,
// request and result codes and default sizes.
// No dependencies.
package mpsm_pkg;

	localparam int NODE_COUNT_DEF    = 1024;
	localparam int ALPHABET_SIZE_DEF = 26;
	localparam int MAX_PAT_LEN_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;

	localparam int ACT_W    = 2;
	localparam int SYM_W    = 5;
	localparam int STATUS_W = 2;
	localparam int START_W  = 32;
	localparam int CNT_W    = 8;
	localparam int LEN_W    = 5;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 48;

	localparam int RESULT_LIMIT = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_COMPILE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MATCH   = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd3;

	localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_COMPILED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd3;

endpackage

/* rtl/mpsm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/multi_pattern_string_matcher.sv */
// Top level of the multi-pattern string matcher (Aho-Corasick automaton).
// Depends on mpsm_pkg and mpsm_ram.
//
// Channel | dir | fields
// --------+-----+-----------------------------------------------------------
// s_*     | in  | tdata: symbol[4:0]; tuser: action[1:0]; tlast: pattern_end
// m_*     | out | tdata: start_position[31:0], multiplicity[39:32],
//         |     |        match_length[44:40]; tuser: status[1:0]; tlast
//
// s_tready is high only in the idle state, so a request is taken only after
// the last one has finished: a load letter, a text letter (which walks the
// output chain of the node it reaches and sends its last result when it
// matches anything), restart or a request that only reports a status. Compile
// scans the root row and then each trie node in breadth-first order; the
// single goto table read port sets the pace of all of these. After reset a
// clearing pass over the NODE_COUNT*ALPHABET_SIZE goto entries zeroes the
// goto, failure and node info tables; no request is taken then.
// A finished result waits in the output register while the next request
// is taken; the output chain walk stalls whenever that register is still
// full and not being emptied.
module multi_pattern_string_matcher #(
	parameter int NODE_COUNT    = mpsm_pkg::NODE_COUNT_DEF,
	parameter int ALPHABET_SIZE = mpsm_pkg::ALPHABET_SIZE_DEF,
	parameter int MAX_PATTERN_LEN = mpsm_pkg::MAX_PAT_LEN_DEF,
	parameter int POSITION_BITS = mpsm_pkg::POSITION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mpsm_pkg::S_TDATA_W-1:0] s_tdata,  // symbol[4:0], zero pad
	input  logic [mpsm_pkg::ACT_W-1:0]     s_tuser,  // action[1:0]
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mpsm_pkg::M_TDATA_W-1:0] m_tdata,  // start, multiplicity, length
	output logic [mpsm_pkg::STATUS_W-1:0]  m_tuser,  // status[1:0]
	output logic                           m_tlast
);

	import mpsm_pkg::*;

	localparam int NB = $clog2(NODE_COUNT);
	localparam int GD = NODE_COUNT * ALPHABET_SIZE;
	localparam int GB = $clog2(GD);
	localparam int CB = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int DB = $clog2(MAX_PATTERN_LEN + 1);
	localparam int KB = $clog2(RESULT_LIMIT + 1);

	typedef struct packed {
		logic [NB-1:0]    olink;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] cnt;
	} info_t;

	// Sequencer states
	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_LD     = 4'd2;
	localparam logic [3:0] S_LD_END = 4'd3;
	localparam logic [3:0] S_EMIT   = 4'd4;
	localparam logic [3:0] S_R0     = 4'd5;
	localparam logic [3:0] S_R1     = 4'd6;
	localparam logic [3:0] S_Q0     = 4'd7;
	localparam logic [3:0] S_Q1     = 4'd8;
	localparam logic [3:0] S_Q2     = 4'd9;
	localparam logic [3:0] S_Q3     = 4'd10;
	localparam logic [3:0] S_E0     = 4'd11;
	localparam logic [3:0] S_E1     = 4'd12;
	localparam logic [3:0] S_E2     = 4'd13;
	localparam logic [3:0] S_M      = 4'd14;
	localparam logic [3:0] S_W      = 4'd15;

	logic [3:0]               state_q;
	logic                     flush_q;     // walk ended, pending result to send
	logic [GB-1:0]            clr_q;
	logic [NB:0]              nodes_q;
	logic [NB-1:0]            ldcur_q;
	logic [DB-1:0]            lddepth_q;
	logic                     compiled_q;
	logic                     disc_q;
	logic [NB-1:0]            cur_q;
	logic [POSITION_BITS-1:0] tp_q;
	logic                     last_q;
	logic [GB-1:0]            slot_q;
	logic [STATUS_W-1:0]      code_q;
	logic [NB:0]              head_q;
	logic [NB:0]              tail_q;
	logic [CB-1:0]            c_q;
	logic [NB-1:0]            i_q;
	logic [NB-1:0]            f_q;
	info_t                    iinfo_q;
	logic [GB-1:0]            ibase_q;
	logic [GB-1:0]            fbase_q;
	logic [NB-1:0]            e_q;
	logic [KB-1:0]            k_q;
	logic                     pend_v_q;
	logic [START_W-1:0]       pend_start_q;
	logic [CNT_W-1:0]         pend_mult_q;
	logic [LEN_W-1:0]         pend_len_q;

	logic                     out_v_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic [START_W-1:0]       out_start_q;
	logic [CNT_W-1:0]         out_mult_q;
	logic [LEN_W-1:0]         out_len_q;
	logic                     out_last_q;

	// RAM ports
	logic          g_we, g_re;
	logic [GB-1:0] g_waddr, g_raddr;
	logic [NB-1:0] g_wdata, g_rdata;
	logic          f_we, f_re;
	logic [NB-1:0] f_waddr, f_raddr, f_wdata, f_rdata;
	logic          n_we, n_re;
	logic [NB-1:0] n_waddr, n_raddr;
	info_t         n_wdata, n_rdata;
	logic          q_we, q_re;
	logic [NB-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

	logic [SYM_W-1:0]         sym;
	logic                     acc, sym_ok, slot_free, clr_node;
	logic [GB-1:0]            ld_slot, m_slot, c_ext;
	logic [NB-1:0]            ld_nxt;
	logic                     ld_full;
	logic                     has, walk_end;
	logic [POSITION_BITS-1:0] st_pos;
	logic [63:0]              st_wide;
	logic                     emit, emit_last;
	logic [STATUS_W-1:0]      emit_status;
	logic [START_W-1:0]       emit_start;
	logic [CNT_W-1:0]         emit_mult;
	logic [LEN_W-1:0]         emit_len;

	assign sym       = s_tdata[SYM_W-1:0];
	assign s_tready  = (state_q == S_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign sym_ok    = 32'(sym) < ALPHABET_SIZE;
	assign slot_free = !out_v_q || m_tready;
	assign clr_node  = 32'(clr_q) < NODE_COUNT;
	assign c_ext     = GB'(c_q);
	assign ld_slot   = GB'(ldcur_q) * GB'(ALPHABET_SIZE) + GB'(sym);
	assign m_slot    = GB'(cur_q) * GB'(ALPHABET_SIZE) + GB'(sym);
	assign ld_full   = 32'(nodes_q) >= NODE_COUNT;
	assign ld_nxt    = (g_rdata == '0) ? nodes_q[NB-1:0] : g_rdata;

	// Output chain evaluation of the node just read
	assign has      = (n_rdata.cnt != '0);
	assign walk_end = (n_rdata.olink == '0) || (has && 32'(k_q) == RESULT_LIMIT - 1);
	assign st_pos   = tp_q + POSITION_BITS'(1) - POSITION_BITS'(n_rdata.len);
	assign st_wide  = 64'(st_pos);

	// Memory access control
	always_comb begin
		g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_re = 1'b0; g_raddr = '0;
		f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
		n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
		q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				g_we = 1'b1;
				g_waddr = clr_q;
				f_we = clr_node;
				f_waddr = clr_q[NB-1:0];
				n_we = clr_node;
				n_waddr = clr_q[NB-1:0];
			end
			S_IDLE: begin
				if (acc && sym_ok) begin
					if (s_tuser == ACT_LOAD && !compiled_q && !disc_q
							&& 32'(lddepth_q) < MAX_PATTERN_LEN) begin
						g_re = 1'b1;
						g_raddr = ld_slot;
					end else if (s_tuser == ACT_MATCH) begin
						g_re = 1'b1;
						g_raddr = m_slot;
					end
				end
			end
			S_LD: begin
				if (g_rdata == '0 && !ld_full) begin
					g_we = 1'b1;
					g_waddr = slot_q;
					g_wdata = nodes_q[NB-1:0];
				end
				if (last_q && !(g_rdata == '0 && ld_full)) begin
					n_re = 1'b1;
					n_raddr = ld_nxt;
				end
			end
			S_LD_END: begin
				n_we = 1'b1;
				n_waddr = ldcur_q;
				n_wdata.olink = n_rdata.olink;
				n_wdata.len = LEN_W'(lddepth_q);
				n_wdata.cnt = (n_rdata.cnt == CNT_MAX) ? CNT_MAX : n_rdata.cnt + 1'b1;
			end
			S_EMIT: begin
			end
			S_R0: begin
				g_re = 1'b1;
				g_raddr = c_ext;
			end
			S_R1: begin
				q_we = (g_rdata != '0);
				q_waddr = tail_q[NB-1:0];
				q_wdata = g_rdata;
			end
			S_Q0: begin
				q_re = (head_q != tail_q);
				q_raddr = head_q[NB-1:0];
			end
			S_Q1: begin
				f_re = 1'b1;
				f_raddr = q_rdata;
				n_re = 1'b1;
				n_raddr = q_rdata;
			end
			S_Q2: begin
				n_re = 1'b1;
				n_raddr = f_rdata;
			end
			S_Q3: begin
				n_we = 1'b1;
				n_waddr = i_q;
				n_wdata = iinfo_q;
				n_wdata.olink = has ? f_q : n_rdata.olink;
			end
			S_E0: begin
				g_re = 1'b1;
				g_raddr = ibase_q + c_ext;
			end
			S_E1: begin
				g_re = 1'b1;
				g_raddr = fbase_q + c_ext;
			end
			S_E2: begin
				if (e_q != '0) begin
					f_we = 1'b1;
					f_waddr = e_q;
					f_wdata = g_rdata;
					q_we = 32'(tail_q) < NODE_COUNT;
					q_waddr = tail_q[NB-1:0];
					q_wdata = e_q;
				end else begin
					g_we = 1'b1;
					g_waddr = ibase_q + c_ext;
					g_wdata = g_rdata;
				end
			end
			S_M: begin
				n_re = (g_rdata != '0);
				n_raddr = g_rdata;
			end
			S_W: begin
				n_re = !flush_q && slot_free && !walk_end;
				n_raddr = n_rdata.olink;
			end
			default: begin
			end
		endcase
	end

	// Result hand-over into the output register
	always_comb begin
		emit = 1'b0;
		emit_last = 1'b1;
		emit_status = ST_MATCH;
		emit_start = '0;
		emit_mult = '0;
		emit_len = '0;
		if (state_q == S_EMIT && slot_free) begin
			emit = 1'b1;
			emit_status = code_q;
		end else if (state_q == S_W && slot_free && pend_v_q && (flush_q || has)) begin
			emit = 1'b1;
			emit_last = flush_q;
			emit_start = pend_start_q;
			emit_mult = pend_mult_q;
			emit_len = pend_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= emit_status;
			out_start_q <= emit_start;
			out_mult_q <= emit_mult;
			out_len_q <= emit_len;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_len_q, out_mult_q, out_start_q};

	// Sequencer and automaton control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			flush_q <= 1'b0;
			clr_q <= '0;
			nodes_q <= (NB+1)'(1);
			ldcur_q <= '0;
			lddepth_q <= '0;
			compiled_q <= 1'b0;
			disc_q <= 1'b0;
			cur_q <= '0;
			tp_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			c_q <= '0;
			k_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == GD - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						unique case (s_tuser)
							ACT_LOAD: begin
								if (sym_ok && !compiled_q) begin
									if (disc_q) begin
										if (s_tlast) begin
											ldcur_q <= '0;
											lddepth_q <= '0;
											disc_q <= 1'b0;
										end
									end else if (32'(lddepth_q) >= MAX_PATTERN_LEN) begin
										if (s_tlast) begin
											ldcur_q <= '0;
											lddepth_q <= '0;
										end else begin
											disc_q <= 1'b1;
										end
										code_q <= ST_TOO_LONG;
										state_q <= S_EMIT;
									end else begin
										slot_q <= ld_slot;
										last_q <= s_tlast;
										state_q <= S_LD;
									end
								end
							end
							ACT_COMPILE: begin
								ldcur_q <= '0;
								lddepth_q <= '0;
								disc_q <= 1'b0;
								code_q <= ST_COMPILED;
								if (compiled_q) begin
									state_q <= S_EMIT;
								end else begin
									head_q <= '0;
									tail_q <= '0;
									c_q <= '0;
									state_q <= S_R0;
								end
							end
							ACT_MATCH: begin
								if (sym_ok) begin
									state_q <= S_M;
								end
							end
							ACT_RESTART: begin
								cur_q <= '0;
								tp_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_LD: begin
					if (g_rdata == '0 && ld_full) begin
						if (last_q) begin
							ldcur_q <= '0;
							lddepth_q <= '0;
						end else begin
							disc_q <= 1'b1;
						end
						code_q <= ST_FULL;
						state_q <= S_EMIT;
					end else begin
						if (g_rdata == '0) begin
							nodes_q <= nodes_q + 1'b1;
						end
						ldcur_q <= ld_nxt;
						lddepth_q <= lddepth_q + 1'b1;
						state_q <= last_q ? S_LD_END : S_IDLE;
					end
				end
				S_LD_END: begin
					ldcur_q <= '0;
					lddepth_q <= '0;
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_R0: begin
					state_q <= S_R1;
				end
				S_R1: begin
					if (g_rdata != '0) begin
						tail_q <= tail_q + 1'b1;
					end
					if (32'(c_q) == ALPHABET_SIZE - 1) begin
						state_q <= S_Q0;
					end else begin
						c_q <= c_q + 1'b1;
						state_q <= S_R0;
					end
				end
				S_Q0: begin
					if (head_q == tail_q) begin
						compiled_q <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						head_q <= head_q + 1'b1;
						state_q <= S_Q1;
					end
				end
				S_Q1: begin
					i_q <= q_rdata;
					state_q <= S_Q2;
				end
				S_Q2: begin
					f_q <= f_rdata;
					iinfo_q <= n_rdata;
					state_q <= S_Q3;
				end
				S_Q3: begin
					ibase_q <= GB'(i_q) * GB'(ALPHABET_SIZE);
					fbase_q <= GB'(f_q) * GB'(ALPHABET_SIZE);
					c_q <= '0;
					state_q <= S_E0;
				end
				S_E0: begin
					state_q <= S_E1;
				end
				S_E1: begin
					e_q <= g_rdata;
					state_q <= S_E2;
				end
				S_E2: begin
					if (e_q != '0 && 32'(tail_q) < NODE_COUNT) begin
						tail_q <= tail_q + 1'b1;
					end
					if (32'(c_q) == ALPHABET_SIZE - 1) begin
						state_q <= S_Q0;
					end else begin
						c_q <= c_q + 1'b1;
						state_q <= S_E0;
					end
				end
				S_M: begin
					cur_q <= g_rdata;
					k_q <= '0;
					pend_v_q <= 1'b0;
					flush_q <= 1'b0;
					if (g_rdata == '0) begin
						tp_q <= tp_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_W;
					end
				end
				S_W: begin
					if (slot_free) begin
						if (flush_q) begin
							// Pending result went out as the last of this letter
							flush_q <= 1'b0;
							pend_v_q <= 1'b0;
							tp_q <= tp_q + 1'b1;
							state_q <= S_IDLE;
						end else begin
							if (has) begin
								pend_v_q <= 1'b1;
								pend_start_q <= st_wide[START_W-1:0];
								pend_mult_q <= n_rdata.cnt;
								pend_len_q <= n_rdata.len;
								k_q <= k_q + 1'b1;
							end
							if (walk_end) begin
								if (has || pend_v_q) begin
									flush_q <= 1'b1;
								end else begin
									tp_q <= tp_q + 1'b1;
									state_q <= S_IDLE;
								end
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mpsm_ram #(.WIDTH(NB), .DEPTH(GD)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata)
	);

	mpsm_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.re(f_re), .raddr(f_raddr), .rdata(f_rdata)
	);

	mpsm_ram #(.WIDTH($bits(info_t)), .DEPTH(NODE_COUNT)) u_info (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rdata)
	);

	mpsm_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.re(q_re), .raddr(q_raddr), .rdata(q_rdata)
	);

endmodule
